// ===== hw/rtl/crc_checked_frame_receiver_top_macros.svh =====
// ----------------------------------------------------------------------------
// CRC-checked frame receiver: assertion macros
// Shorthand for the concurrent checks of the receiver, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH
`define CRC_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication.
`define CCFR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication.
`define CCFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

// ===== hw/rtl/ccfr_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-checked frame receiver package
// Frame constants, phase encoding and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfr_pkg;

  // Frame layout.
  localparam int unsigned MaxFrameLen   = 32;
  localparam int unsigned FrameOverhead = 6;
  localparam int unsigned PayLenW       = $clog2(MaxFrameLen - FrameOverhead + 1);

  localparam logic [7:0]  StartByte = 8'h01;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;

  // Result kind codes.
  localparam logic ResKindData   = 1'b0;
  localparam logic ResKindStatus = 1'b1;

  // Receive phase, one-hot.
  typedef enum logic [6:0] {
    PhHunt = 7'b0000001,
    PhLen  = 7'b0000010,
    PhType = 7'b0000100,
    PhOpt  = 7'b0001000,
    PhData = 7'b0010000,
    PhCrcL = 7'b0100000,
    PhCrcH = 7'b1000000
  } phase_e;

  // One byte of CRC-16, polynomial 0x1021 MSB first, with the byte
  // bit-reversed before it is folded in.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  rev;
    logic [15:0] c;
    for (int i = 0; i < 8; i++) begin
      rev[7 - i] = b[i];
    end
    c = crc ^ {rev, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ccfr_rx_if.sv =====
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ccfr_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one payload or end-of-frame result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccfr_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] msg_type;
  logic [7:0] msg_options;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic [4:0] payload_len;
  logic       crc_ok;
  logic       frame_end;

  modport source (output valid, output result_kind, output msg_type, output msg_options,
                  output data_byte, output byte_index, output payload_len,
                  output crc_ok, output frame_end, input ready);
  modport sink   (input valid, input result_kind, input msg_type, input msg_options,
                  input data_byte, input byte_index, input payload_len,
                  input crc_ok, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/crc_checked_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// CRC-checked frame receiver
// Deframes a byte stream, passes payload bytes out and reports the CRC check.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries received bytes, one per beat. The receiver hunts for the
//   start byte 0x01, then takes length, type, options, payload and a
//   little-endian CRC. res_o carries one beat per payload byte and one
//   end-of-frame status beat after the CRC high byte.
//   Latency: a result appears on res_o the cycle after its byte is taken.
//   Throughput: one byte per cycle unless res_o stalls; the CRC update and
//   phase step both complete in the cycle the byte is accepted.
//   Reset: the receiver returns to hunting with the CRC preset to 0xFFFF
//   and the result register empty.
//   Stall: a single result register sits on res_o. While it is full and
//   res_o.ready is low, rx_i.ready is low; when the result is taken in the
//   same cycle, a new byte is accepted alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_receiver_top
  import ccfr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ccfr_rx_if.sink     rx_i,
  ccfr_res_if.source  res_o
);

  `include "crc_checked_frame_receiver_top_macros.svh"

  // Frame state.
  phase_e               phase_q, phase_d;
  logic [15:0]          crc_q, crc_d;
  logic [PayLenW-1:0]   len_q, len_d;
  logic [PayLenW-1:0]   cnt_q, cnt_d;
  logic [7:0]           type_q, type_d;
  logic [7:0]           opt_q, opt_d;
  logic [7:0]           crc_lo_q, crc_lo_d;

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic                 out_kind_q, out_kind_d;
  logic [7:0]           out_data_q, out_data_d;
  logic [4:0]           out_index_q, out_index_d;
  logic [4:0]           out_len_q, out_len_d;
  logic                 out_ok_q, out_ok_d;
  logic [7:0]           out_type_q, out_type_d;
  logic [7:0]           out_opt_q, out_opt_d;

  logic                 accept;
  logic [7:0]           b;
  logic [15:0]          crc_upd;
  logic [PayLenW-1:0]   cnt_inc;
  logic [7:0]           len_wide;
  logic [7:0]           cnt_wide;
  logic                 len_in_range;

  // Take a byte whenever the result register is free or being emptied.
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  assign crc_upd      = crc_feed(crc_q, b);
  assign cnt_inc      = cnt_q + PayLenW'(1);
  assign len_wide     = 8'(len_q);
  assign cnt_wide     = 8'(cnt_q);
  assign len_in_range = (b >= 8'(FrameOverhead)) && (b <= 8'(MaxFrameLen));

  // Phase step and result formation.
  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    type_d      = type_q;
    opt_d       = opt_q;
    crc_lo_d    = crc_lo_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_kind_d  = out_kind_q;
    out_data_d  = out_data_q;
    out_index_d = out_index_q;
    out_len_d   = out_len_q;
    out_ok_d    = out_ok_q;
    out_type_d  = out_type_q;
    out_opt_d   = out_opt_q;

    if (accept) begin
      case (phase_q)
        PhLen: begin
          if (len_in_range) begin
            len_d   = PayLenW'(b - 8'(FrameOverhead));
            crc_d   = crc_upd;
            phase_d = PhType;
          end else if (b == StartByte) begin
            crc_d   = crc_feed(CrcInit, StartByte);
            phase_d = PhLen;
          end else begin
            crc_d   = CrcInit;
            phase_d = PhHunt;
          end
        end
        PhType: begin
          type_d  = b;
          crc_d   = crc_upd;
          phase_d = PhOpt;
        end
        PhOpt: begin
          opt_d   = b;
          crc_d   = crc_upd;
          cnt_d   = '0;
          phase_d = (len_q == '0) ? PhCrcL : PhData;
        end
        PhData: begin
          crc_d       = crc_upd;
          out_valid_d = 1'b1;
          out_kind_d  = ResKindData;
          out_type_d  = type_q;
          out_opt_d   = opt_q;
          out_data_d  = b;
          out_index_d = cnt_wide[4:0];
          out_len_d   = len_wide[4:0];
          out_ok_d    = 1'b0;
          cnt_d       = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PhCrcL;
          end
        end
        PhCrcL: begin
          crc_lo_d = b;
          phase_d  = PhCrcH;
        end
        PhCrcH: begin
          out_valid_d = 1'b1;
          out_kind_d  = ResKindStatus;
          out_type_d  = type_q;
          out_opt_d   = opt_q;
          out_data_d  = 8'h00;
          out_index_d = 5'd0;
          out_len_d   = len_wide[4:0];
          out_ok_d    = ({b, crc_lo_q} == crc_q);
          crc_d       = CrcInit;
          phase_d     = PhHunt;
        end
        default: begin
          // Hunting, and any unused phase code.
          if (b == StartByte) begin
            crc_d   = crc_feed(CrcInit, StartByte);
            phase_d = PhLen;
          end else begin
            crc_d   = CrcInit;
            phase_d = PhHunt;
          end
        end
      endcase
    end
  end

  // Control and frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      crc_q       <= CrcInit;
      len_q       <= '0;
      cnt_q       <= '0;
      type_q      <= 8'h00;
      opt_q       <= 8'h00;
      crc_lo_q    <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      crc_q       <= crc_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      type_q      <= type_d;
      opt_q       <= opt_d;
      crc_lo_q    <= crc_lo_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_data_q  <= out_data_d;
    out_index_q <= out_index_d;
    out_len_q   <= out_len_d;
    out_ok_q    <= out_ok_d;
    out_type_q  <= out_type_d;
    out_opt_q   <= out_opt_d;
  end

  // Result channel outputs.
  assign res_o.valid       = out_valid_q;
  assign res_o.result_kind = out_kind_q;
  assign res_o.msg_type    = out_type_q;
  assign res_o.msg_options = out_opt_q;
  assign res_o.data_byte   = out_data_q;
  assign res_o.byte_index  = out_index_q;
  assign res_o.payload_len = out_len_q;
  assign res_o.crc_ok      = out_ok_q;
  assign res_o.frame_end   = (out_kind_q == ResKindStatus);

  // Checks.
  `CCFR_ASSERT_SAME(a_data_count_in_range, phase_q == PhData, cnt_q < len_q)
  `CCFR_ASSERT_NEXT(a_status_after_crc_high, accept && phase_q == PhCrcH,
                    out_valid_q && out_kind_q == ResKindStatus && phase_q == PhHunt)
  `CCFR_ASSERT_NEXT(a_hunt_keeps_preset, accept && phase_q == PhHunt && b != StartByte,
                    phase_q == PhHunt && crc_q == CrcInit)
  `CCFR_ASSERT_SAME(a_ready_when_empty, !out_valid_q, rx_i.ready)
  `CCFR_ASSERT_NEXT(a_no_result_outside_data, accept && phase_q != PhData &&
                    phase_q != PhCrcH && !out_valid_q, !out_valid_q)

endmodule

`default_nettype wire
